>>> sv/gaps_pkg.sv
// Package: shared types and constants for the grid path search unit.
package gaps_pkg;
    localparam int GridSide  = 8;
    localparam int Cells     = 64;
    localparam int OpenDepth = 256;
    localparam logic [6:0] CostInf = 7'd127;

    typedef struct packed {
        logic       req_type;
        logic [2:0] cell_row;
        logic [2:0] cell_col;
        logic       blocked;
        logic [2:0] src_row;
        logic [2:0] src_col;
        logic [2:0] dst_row;
        logic [2:0] dst_col;
    } t_req;

    typedef struct packed {
        logic [2:0] path_row;
        logic [2:0] path_col;
        logic [5:0] distance;
        logic       reachable;
        logic       last;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_SCAN, S_POP, S_NBR_RD, S_NBR, S_TRACE_RD, S_TRACE,
        S_EMIT_RD, S_EMIT, S_FAIL
    } t_state;

    function automatic logic [2:0] absdiff(input logic [2:0] a, input logic [2:0] b);
        return (a > b) ? a - b : b - a;
    endfunction
endpackage

>>> sv/gaps_if.sv
// Interfaces: valid/ready channels for requests and results.
interface gaps_req_if;
    logic            valid;
    logic            ready;
    gaps_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gaps_rsp_if;
    logic            valid;
    logic            ready;
    gaps_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/grid_astar_path_search_unit.sv
// Top level: A* search engine with a sequencer around one open-list scan unit.
// Sequence: a load is taken in idle. A search takes its accept and clears all 64 cells,
// then per pop scans the open list, pops the best entry and, for an expanded
// cell, relaxes its four neighbours; then it traces the parents back and emits
// one beat per path cell, and the emitting waits on output stalls.
// Throughput: one item at a time, ready low until the last beat is loaded.
// Reset: synchronous active low; clears the obstacle map and sequencer.
module grid_astar_path_search_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gaps_req_if.sink     i_req,
    gaps_rsp_if.source   o_rsp
);
    // obstacle map: 64 flops, cleared at reset
    logic [63:0]  r_obst;
    // per-search stores
    logic [6:0]   r_cost   [64];
    logic [6:0]   r_par    [64];
    logic [63:0]  r_closed;
    logic [12:0]  r_open   [256];
    logic [5:0]   r_stack  [64];

    gaps_pkg::t_state r_st, n_st;
    logic [8:0]  r_cnt;        // open count
    logic [8:0]  r_i;          // scan index / clear index
    logic [7:0]  r_best;
    logic [12:0] r_bkey;
    logic [12:0] r_rd;         // registered open-list read
    logic [12:0] r_tail;       // last open entry, captured during the scan
    logic [2:0]  r_sr, r_sc, r_dr, r_dc;
    logic [5:0]  r_cur;
    logic [6:0]  r_g;
    logic [1:0]  r_dir;
    logic [6:0]  r_ncost;
    logic [6:0]  r_npar;
    logic [6:0]  r_n;          // path length
    logic [6:0]  r_k;
    logic [5:0]  r_dist;
    logic [5:0]  r_cell;
    logic        r_ov;
    gaps_pkg::t_rsp r_od;

    wire in_fire  = i_req.valid && i_req.ready;
    wire out_fire = o_rsp.valid && o_rsp.ready;
    assign i_req.ready = (r_st == gaps_pkg::S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_od;

    wire [5:0] src = {r_sr, r_sc};
    wire [5:0] dst = {r_dr, r_dc};

    // heuristic of the source cell, pushed as the first open entry
    wire [6:0] start_f = {4'd0, gaps_pkg::absdiff(i_req.data.src_row, i_req.data.dst_row)}
                       + {4'd0, gaps_pkg::absdiff(i_req.data.src_col, i_req.data.dst_col)};

    // neighbor coordinates of r_cur in direction r_dir
    logic [2:0] nr, nc;
    logic       nok;
    always_comb begin
        nr = r_cur[5:3]; nc = r_cur[2:0]; nok = 1'b1;
        case (r_dir)
            2'd0: begin nok = (r_cur[5:3] != 3'd0); nr = r_cur[5:3] - 3'd1; end
            2'd1: begin nok = (r_cur[5:3] != 3'd7); nr = r_cur[5:3] + 3'd1; end
            2'd2: begin nok = (r_cur[2:0] != 3'd0); nc = r_cur[2:0] - 3'd1; end
            default: begin nok = (r_cur[2:0] != 3'd7); nc = r_cur[2:0] + 3'd1; end
        endcase
    end
    wire [5:0] nidx = {nr, nc};
    wire [6:0] ng   = r_g + 7'd1;
    wire [6:0] nf   = ng + {4'd0, gaps_pkg::absdiff(nr, r_dr)}
                         + {4'd0, gaps_pkg::absdiff(nc, r_dc)};
    wire relax = nok && !r_obst[nidx] && !r_closed[nidx] && (ng < r_ncost);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            gaps_pkg::S_IDLE:
                if (in_fire && i_req.data.req_type) n_st = gaps_pkg::S_CLEAR;
            gaps_pkg::S_CLEAR:  if (r_i[5:0] == 6'd63) n_st = gaps_pkg::S_SCAN;
            gaps_pkg::S_SCAN: begin
                if (r_cnt == 9'd0) n_st = gaps_pkg::S_FAIL;
                else if (r_i == r_cnt) n_st = gaps_pkg::S_POP;
            end
            gaps_pkg::S_POP: begin
                if (r_closed[r_bkey[5:0]]) n_st = gaps_pkg::S_SCAN;
                else if (r_bkey[5:0] == dst) n_st = gaps_pkg::S_TRACE_RD;
                else n_st = gaps_pkg::S_NBR_RD;
            end
            gaps_pkg::S_NBR_RD: n_st = gaps_pkg::S_NBR;
            gaps_pkg::S_NBR:
                if (r_dir == 2'd3) n_st = gaps_pkg::S_SCAN;
                else n_st = gaps_pkg::S_NBR_RD;
            gaps_pkg::S_TRACE_RD: n_st = gaps_pkg::S_TRACE;
            gaps_pkg::S_TRACE:
                if (r_cur == src || r_npar[6] || r_n == 7'd63) n_st = gaps_pkg::S_EMIT_RD;
                else n_st = gaps_pkg::S_TRACE_RD;
            gaps_pkg::S_EMIT_RD: if (!r_ov || out_fire) n_st = gaps_pkg::S_EMIT;
            gaps_pkg::S_EMIT:
                n_st = (r_k == r_n - 7'd1) ? gaps_pkg::S_IDLE : gaps_pkg::S_EMIT_RD;
            gaps_pkg::S_FAIL: if (!r_ov || out_fire) n_st = gaps_pkg::S_IDLE;
            default: n_st = gaps_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= gaps_pkg::S_IDLE;
        else r_st <= n_st;
    end

    // memories and datapath
    always_ff @(posedge i_clk) begin
        r_rd   <= r_open[r_i[7:0]];
        r_ncost <= r_cost[nidx];
        r_npar  <= r_par[r_cur];
        r_cell  <= r_stack[6'(r_n - 7'd1 - r_k)];
        case (r_st)
            gaps_pkg::S_CLEAR: begin
                r_cost[r_i[5:0]] <= (r_i[5:0] == src) ? 7'd0 : gaps_pkg::CostInf;
                r_par[r_i[5:0]]  <= gaps_pkg::CostInf;
            end
            gaps_pkg::S_POP: r_open[r_best] <= r_tail;
            gaps_pkg::S_NBR: if (relax) begin
                r_cost[nidx] <= ng;
                r_par[nidx]  <= {1'b0, r_cur};
                if (r_cnt < 9'(gaps_pkg::OpenDepth)) r_open[r_cnt[7:0]] <= {nf, nidx};
            end
            gaps_pkg::S_TRACE: r_stack[r_n[5:0]] <= r_cur;
            default: ;
        endcase
        if (r_st == gaps_pkg::S_IDLE && in_fire && i_req.data.req_type)
            r_open[0] <= {start_f, i_req.data.src_row, i_req.data.src_col};
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obst <= '0;
            r_ov   <= 1'b0;
            r_cnt  <= '0;
            r_i    <= '0;
            r_closed <= '0;
        end else begin
            // raise valid when a beat is loaded, drop it once taken
            if (r_st == gaps_pkg::S_EMIT ||
                (r_st == gaps_pkg::S_FAIL && (!r_ov || out_fire))) r_ov <= 1'b1;
            else if (out_fire) r_ov <= 1'b0;
            unique case (r_st)
                gaps_pkg::S_IDLE: if (in_fire) begin
                    if (!i_req.data.req_type)
                        r_obst[{i_req.data.cell_row, i_req.data.cell_col}] <= i_req.data.blocked;
                    else begin
                        r_sr <= i_req.data.src_row; r_sc <= i_req.data.src_col;
                        r_dr <= i_req.data.dst_row; r_dc <= i_req.data.dst_col;
                        r_cnt <= 9'd1; r_i <= '0; r_closed <= '0;
                    end
                end
                gaps_pkg::S_CLEAR: begin
                    r_i <= (r_i[5:0] == 6'd63) ? 9'd0 : r_i + 9'd1;
                end
                gaps_pkg::S_SCAN: begin
                    // r_rd holds entry r_i-1; compare and advance
                    if (r_i != 9'd0 && (r_i == 9'd1 || r_rd < r_bkey)) begin
                        r_bkey <= r_rd; r_best <= 8'(r_i - 9'd1);
                    end
                    if (r_i == r_cnt) begin
                        r_tail <= r_rd;
                        r_i <= '0;
                    end else r_i <= r_i + 9'd1;
                end
                gaps_pkg::S_POP: begin
                    r_cnt <= r_cnt - 9'd1;
                    r_cur <= r_bkey[5:0];
                    r_g   <= r_cost[r_bkey[5:0]];
                    r_dir <= 2'd0;
                    r_n   <= '0;
                    if (!r_closed[r_bkey[5:0]]) r_closed[r_bkey[5:0]] <= 1'b1;
                    r_dist <= r_cost[r_bkey[5:0]][5:0];
                end
                gaps_pkg::S_NBR: begin
                    r_dir <= r_dir + 2'd1;
                    if (relax && r_cnt < 9'(gaps_pkg::OpenDepth)) r_cnt <= r_cnt + 9'd1;
                end
                gaps_pkg::S_TRACE: begin
                    r_n <= r_n + 7'd1;
                    r_cur <= r_npar[5:0];
                    r_k <= '0;
                end
                gaps_pkg::S_EMIT_RD: ;
                gaps_pkg::S_EMIT: begin
                    r_od <= '{path_row: r_cell[5:3], path_col: r_cell[2:0],
                              distance: r_dist, reachable: 1'b1,
                              last: (r_k == r_n - 7'd1)};
                    r_k <= r_k + 7'd1;
                end
                gaps_pkg::S_FAIL: if (!r_ov || out_fire) begin
                    r_od <= '{path_row: 3'd0, path_col: 3'd0, distance: 6'd0,
                              reachable: 1'b0, last: 1'b1};
                end
                default: ;
            endcase
        end
    end
endmodule

>>> tb/grid_astar_path_search_unit_tb.sv
// Testbench for the grid A* path search unit: predicts each search and checks every path beat.
`timescale 1ns / 100ps

module grid_astar_path_search_unit_tb;
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    gaps_req_if req_ch ();
    gaps_rsp_if rsp_ch ();

    grid_astar_path_search_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Predictor state: the persistent obstacle map and the queue of due path beats.
    logic                wall_map [gaps_pkg::Cells];
    gaps_pkg::t_rsp      path_beats_due [$];
    int                  error_count = 0;
    bit                  idle_enable = 1'b1;

    // Return the Manhattan distance between two cells.
    function automatic int grid_dist(int r, int c, int dr, int dc);
        return (r > dr ? r - dr : dr - r) + (c > dc ? c - dc : dc - c);
    endfunction

    // Apply one request to the predictor and queue the path beats it yields.
    task automatic predict_request(input gaps_pkg::t_req rq);
        int         cost [gaps_pkg::Cells];
        bit         closed [gaps_pkg::Cells];
        int         parent [gaps_pkg::Cells];
        logic [12:0] heap [$];
        int         src, dst, best, idx, r, c, nr, nc, nidx, ng, n, cur;
        int         trail [gaps_pkg::Cells];
        logic [12:0] key;
        gaps_pkg::t_rsp beat;
        if (!rq.req_type) begin
            wall_map[rq.cell_row * gaps_pkg::GridSide + rq.cell_col] = rq.blocked;
            return;
        end
        for (int i = 0; i < gaps_pkg::Cells; i++) begin
            cost[i] = gaps_pkg::CostInf;
            closed[i] = 1'b0;
            parent[i] = 127;
        end
        src = rq.src_row * gaps_pkg::GridSide + rq.src_col;
        dst = rq.dst_row * gaps_pkg::GridSide + rq.dst_col;
        cost[src] = 0;
        key = {7'(grid_dist(rq.src_row, rq.src_col, rq.dst_row, rq.dst_col)),
               rq.src_row, rq.src_col};
        heap = {heap, key};
        while (heap.size() > 0) begin
            best = 0;
            for (int i = 1; i < heap.size(); i++)
                if (heap[i] < heap[best]) best = i;
            key = heap[best];
            // Pop by moving the tail entry into the hole, as the hardware list does.
            heap[best] = heap[heap.size() - 1];
            void'(heap.pop_back());
            r = key[5:3];
            c = key[2:0];
            idx = r * gaps_pkg::GridSide + c;
            if (closed[idx]) continue;
            closed[idx] = 1'b1;
            if (idx == dst) break;
            for (int d = 0; d < 4; d++) begin
                nr = r + (d == 0 ? -1 : d == 1 ? 1 : 0);
                nc = c + (d == 2 ? -1 : d == 3 ? 1 : 0);
                if (nr < 0 || nc < 0 || nr >= gaps_pkg::GridSide || nc >= gaps_pkg::GridSide)
                    continue;
                nidx = nr * gaps_pkg::GridSide + nc;
                if (wall_map[nidx] || closed[nidx]) continue;
                ng = cost[idx] + 1;
                if (ng < cost[nidx]) begin
                    cost[nidx] = ng;
                    parent[nidx] = idx;
                    if (heap.size() < gaps_pkg::OpenDepth) begin
                        key = {7'(ng + grid_dist(nr, nc, rq.dst_row, rq.dst_col)),
                               3'(nr), 3'(nc)};
                        heap = {heap, key};
                    end
                end
            end
        end
        if (!closed[dst]) begin
            beat = '{path_row: 3'd0, path_col: 3'd0, distance: 6'd0, reachable: 1'b0,
                     last: 1'b1};
            path_beats_due = {path_beats_due, beat};
            return;
        end
        n = 0;
        cur = dst;
        while (n < gaps_pkg::Cells) begin
            trail[n] = cur;
            n++;
            if (cur == src || parent[cur] >= gaps_pkg::Cells) break;
            cur = parent[cur];
        end
        for (int k = 0; k < n; k++) begin
            beat.path_row  = 3'(trail[n - 1 - k] / gaps_pkg::GridSide);
            beat.path_col  = 3'(trail[n - 1 - k] % gaps_pkg::GridSide);
            beat.distance  = 6'(cost[dst]);
            beat.reachable = 1'b1;
            beat.last      = (k == n - 1);
            path_beats_due = {path_beats_due, beat};
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Drive one beat, with a random idle gap before it, and wait for acceptance.
    task automatic send_request(input gaps_pkg::t_req rq);
        while (idle_enable && $urandom_range(99) < 24) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= rq;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_request(rq);
    endtask

    task automatic load_cell(input int r, input int c, input bit blk);
        gaps_pkg::t_req rq;
        rq = gaps_pkg::t_req'(20'($urandom));
        rq.req_type = 1'b0;
        rq.cell_row = 3'(r);
        rq.cell_col = 3'(c);
        rq.blocked  = blk;
        send_request(rq);
    endtask

    task automatic run_search(input int sr, input int sc, input int dr, input int dc);
        gaps_pkg::t_req rq;
        rq = gaps_pkg::t_req'(20'($urandom));
        rq.req_type = 1'b1;
        rq.src_row = 3'(sr);
        rq.src_col = 3'(sc);
        rq.dst_row = 3'(dr);
        rq.dst_col = 3'(dc);
        send_request(rq);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (path_beats_due.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Result side: stall at random, compare each beat against the oldest prediction.
    always @(posedge i_clk) begin
        gaps_pkg::t_rsp want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (path_beats_due.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = path_beats_due.pop_front();
                    if (rsp_ch.data.path_row != want.path_row)
                        report_mismatch("path_row", rsp_ch.data.path_row, want.path_row);
                    if (rsp_ch.data.path_col != want.path_col)
                        report_mismatch("path_col", rsp_ch.data.path_col, want.path_col);
                    if (rsp_ch.data.distance != want.distance)
                        report_mismatch("distance", rsp_ch.data.distance, want.distance);
                    if (rsp_ch.data.reachable != want.reachable)
                        report_mismatch("reachable", rsp_ch.data.reachable, want.reachable);
                    if (rsp_ch.data.last != want.last)
                        report_mismatch("last", rsp_ch.data.last, want.last);
                end
            end
            rsp_ch.ready <= !(idle_enable && $urandom_range(99) < 24);
        end
    end

    // Corners, walls, blocked endpoints, same-cell and unreachable searches.
    task automatic test_directed();
        run_search(0, 0, 7, 7);
        run_search(7, 7, 0, 0);
        run_search(3, 4, 3, 4);
        load_cell(0, 1, 1);
        load_cell(1, 0, 1);
        run_search(0, 0, 5, 5);
        run_search(5, 5, 0, 0);
        run_search(0, 0, 0, 0);
        load_cell(7, 7, 1);
        run_search(0, 7, 7, 7);
        load_cell(0, 1, 0);
        load_cell(1, 0, 0);
        load_cell(7, 7, 0);
        // Build a vertical wall at column 4 with a gap at row 7.
        for (int r = 0; r < 7; r++) load_cell(r, 4, 1);
        run_search(0, 0, 0, 7);
        load_cell(7, 4, 1);
        run_search(0, 0, 0, 7);
        for (int r = 0; r < 8; r++) load_cell(r, 4, 0);
        drain_results();
    endtask

    // Random obstacle maps followed by bursts of searches.
    task automatic test_random_maps(input int rounds);
        int density;
        for (int k = 0; k < rounds; k++) begin
            density = $urandom_range(40);
            for (int i = 0; i < 6; i++)
                load_cell($urandom_range(7), $urandom_range(7), $urandom_range(99) < density);
            for (int i = 0; i < 4; i++)
                run_search($urandom_range(7), $urandom_range(7),
                           $urandom_range(7), $urandom_range(7));
            if (k % 8 == 7) drain_results();
        end
    endtask

    // Hold the sender until every prediction is consumed, with no idling on either side.
    task automatic test_back_pressure();
        idle_enable = 1'b0;
        for (int i = 0; i < 20; i++)
            run_search($urandom_range(7), $urandom_range(7),
                       $urandom_range(7), $urandom_range(7));
        drain_results();
        idle_enable = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < gaps_pkg::Cells; i++) wall_map[i] = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_maps(20);
        test_back_pressure();
        test_random_maps(17);
        drain_results();
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && path_beats_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #1000ms;
        $display("tb: failure");
        $finish;
    end
endmodule
